### hdl/fcl_pkg.sv
// Package for the fully connected layer: payload structs, mode and register
// codes, and the fixed widths shared by the store, the MAC unit and the top level.
package fcl_pkg;

  // Index fields are four bits wide, so no store dimension goes past this.
  localparam int FIELD_LIMIT = 16;

  // Exact sum of up to sixteen Q16.16 products plus a Q8.8 bias moved to Q16.16.
  localparam int ACC_W = 36;

  localparam int COUNT_W = 5;
  localparam int CFG_INDEX_W = 4;

  localparam logic [1:0] MODE_ELEMENT = 2'd0;
  localparam logic [1:0] MODE_WEIGHT  = 2'd1;
  localparam logic [1:0] MODE_BIAS    = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] REG_INPUT_COUNT  = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_OUTPUT_COUNT = 4'd1;

  typedef struct packed {
    logic [1:0]         mode;
    logic [3:0]         row;
    logic [3:0]         column;
    logic signed [15:0] value;
    logic               last;
  } in_item_t;

  typedef struct packed {
    logic [3:0]         out_index;
    logic signed [15:0] result;
    logic               saturated;
    logic               final_res;
  } out_item_t;

  // Control that travels with each operand pair into the MAC unit.
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } mac_ctl_t;

endpackage

### hdl/fcl_store.sv
// Weight, input vector and bias storage for the fully connected layer.
// Writes come from accepted input items; reads are registered. Uses fcl_pkg.
module fcl_store #(
  parameter int ROWS = 16,
  parameter int COLS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_en,
  input  fcl_pkg::in_item_t             wr_item,
  input  logic [(ROWS > 1 ? $clog2(ROWS) : 1)-1:0] rd_row,
  input  logic [(COLS > 1 ? $clog2(COLS) : 1)-1:0] rd_col,
  output logic signed [15:0]            weight_q,
  output logic signed [15:0]            element_q,
  output logic signed [15:0]            bias_q
);

  localparam int RW  = ROWS > 1 ? $clog2(ROWS) : 1;
  localparam int CW  = COLS > 1 ? $clog2(COLS) : 1;
  localparam int WAW = (ROWS * COLS) > 1 ? $clog2(ROWS * COLS) : 1;

  logic signed [15:0] weight_mem [ROWS*COLS];
  logic signed [15:0] vector_mem [COLS];
  logic signed [15:0] bias_mem [ROWS];
  logic [ROWS-1:0]    bias_valid;

  logic           row_ok;
  logic           col_ok;
  logic [WAW-1:0] wr_addr;
  logic [WAW-1:0] rd_addr;

  assign row_ok  = int'(wr_item.row) < ROWS;
  assign col_ok  = int'(wr_item.column) < COLS;
  assign wr_addr = WAW'(int'(wr_item.row) * COLS + int'(wr_item.column));
  assign rd_addr = WAW'(int'(rd_row) * COLS + int'(rd_col));

  always_ff @(posedge clk) begin
    if (wr_en && wr_item.mode == fcl_pkg::MODE_WEIGHT && row_ok && col_ok) begin
      weight_mem[wr_addr] <= wr_item.value;
    end
    if (wr_en && wr_item.mode == fcl_pkg::MODE_ELEMENT && col_ok) begin
      vector_mem[wr_item.column[CW-1:0]] <= wr_item.value;
    end
    if (wr_en && wr_item.mode == fcl_pkg::MODE_BIAS && row_ok) begin
      bias_mem[wr_item.row[RW-1:0]] <= wr_item.value;
    end
    weight_q  <= weight_mem[rd_addr];
    element_q <= vector_mem[rd_col];
    bias_q    <= bias_valid[rd_row] ? bias_mem[rd_row] : 16'sd0;
  end

  // Biases read as zero until written.
  always_ff @(posedge clk) begin
    if (rst) begin
      bias_valid <= '0;
    end else if (wr_en && wr_item.mode == fcl_pkg::MODE_BIAS && row_ok) begin
      bias_valid[wr_item.row[RW-1:0]] <= 1'b1;
    end
  end

endmodule

### hdl/fcl_mac.sv
// Shared multiply-accumulate unit with Q8.8 rounding and saturation.
// One registered multiply stage, one accumulate stage. Uses fcl_pkg.
module fcl_mac (
  input  logic                 clk,
  input  logic                 rst,
  input  fcl_pkg::mac_ctl_t    ctl,
  input  logic signed [15:0]   weight,
  input  logic signed [15:0]   element,
  input  logic signed [15:0]   bias,
  output logic                 done,
  output logic signed [15:0]   result,
  output logic                 saturated
);

  localparam int ACC_W = fcl_pkg::ACC_W;
  localparam int Q_W   = ACC_W - 8;

  fcl_pkg::mac_ctl_t        ctl_a;
  logic signed [31:0]       prod;
  logic signed [15:0]       bias_a;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  prod_ext;
  logic signed [ACC_W-1:0]  bias_ext;
  logic signed [ACC_W-1:0]  rounded;
  logic signed [Q_W-1:0]    q;
  logic                     over_pos;
  logic                     over_neg;

  always_ff @(posedge clk) begin
    prod   <= weight * element;
    bias_a <= bias;
    if (ctl_a.valid) begin
      acc <= ctl_a.first ? bias_ext + prod_ext : acc + prod_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_a <= '0;
      done  <= 1'b0;
    end else begin
      ctl_a <= ctl;
      done  <= ctl_a.valid && ctl_a.last;
    end
  end

  assign prod_ext = {{(ACC_W-32){prod[31]}}, prod};
  assign bias_ext = {{(ACC_W-24){bias_a[15]}}, bias_a, 8'd0};

  // Add half an LSB, then the arithmetic shift floors, so ties round up.
  assign rounded  = acc + ACC_W'(128);
  assign q        = rounded[ACC_W-1:8];
  assign over_pos = !q[Q_W-1] && (|q[Q_W-2:15]);
  assign over_neg = q[Q_W-1] && !(&q[Q_W-2:15]);

  always_comb begin
    saturated = over_pos || over_neg;
    if (over_pos) begin
      result = 16'sh7fff;
    end else if (over_neg) begin
      result = -16'sh8000;
    end else begin
      result = q[15:0];
    end
  end

endmodule

### hdl/fully_connected_layer.sv
// Fully connected layer top level: sequencer, configuration registers and the
// output register. Depends on fcl_pkg, fcl_store and fcl_mac.
//
// The block keeps a weight matrix, a bias vector and an input vector, all in
// signed Q8.8, and loads them one value per input transfer: mode 0 writes an
// input element, mode 1 a weight, mode 2 a bias. An element transfer with last
// set also starts the computation, and the block then delivers output_count
// results in order of output feature, each bias plus the dot product of its
// weight row with the first input_count elements, rounded to Q8.8 with ties
// going up and saturated to the 16-bit range. One multiply-accumulate unit does
// all the work, one weight per cycle while a row is issued; each result first
// claims the output register, then issues input_count reads and multiplies,
// then drains the read, multiply and accumulate stages. Loading transfers
// are accepted whenever the input side is ready. While a vector is being
// computed the input side is not ready; it becomes ready again as soon as
// the last result sits in the output register, even if that result has not
// yet been taken. Weights and elements that were never written read back as
// whatever the memory holds; biases read as zero until written. Counts
// written through the configuration port are clamped to the range the store
// supports.
module fully_connected_layer #(
  parameter int MAX_INPUTS  = 16,
  parameter int MAX_OUTPUTS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  fcl_pkg::in_item_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output fcl_pkg::out_item_t                res_data,
  input  logic                              cfg_we,
  input  logic [fcl_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [fcl_pkg::COUNT_W-1:0]       cfg_data
);

  // Only as many rows and columns as the four-bit index fields can reach.
  localparam int ROWS = MAX_OUTPUTS < fcl_pkg::FIELD_LIMIT ? MAX_OUTPUTS
                                                           : fcl_pkg::FIELD_LIMIT;
  localparam int COLS = MAX_INPUTS < fcl_pkg::FIELD_LIMIT ? MAX_INPUTS
                                                          : fcl_pkg::FIELD_LIMIT;
  localparam int RW   = ROWS > 1 ? $clog2(ROWS) : 1;
  localparam int CW   = COLS > 1 ? $clog2(COLS) : 1;
  localparam int NW   = fcl_pkg::COUNT_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WAIT,
    S_ISSUE,
    S_DRAIN
  } state_t;

  state_t             state;
  logic [RW-1:0]      k;
  logic [CW-1:0]      c;
  logic [NW-1:0]      input_count;
  logic [NW-1:0]      output_count;
  logic [NW-1:0]      input_last;
  logic [NW-1:0]      output_last;
  logic [NW-1:0]      cfg_inputs;
  logic [NW-1:0]      cfg_outputs;

  fcl_pkg::mac_ctl_t  issue_ctl;
  fcl_pkg::mac_ctl_t  read_ctl;
  logic               in_xfer;
  logic signed [15:0] weight_q;
  logic signed [15:0] element_q;
  logic signed [15:0] bias_q;
  logic               mac_done;
  logic signed [15:0] mac_result;
  logic               mac_sat;

  assign in_ready    = state == S_IDLE;
  assign in_xfer     = in_valid && in_ready;
  assign input_last  = input_count - NW'(1);
  assign output_last = output_count - NW'(1);

  // Clamp counts to at least one and at most the store dimension.
  always_comb begin
    if (cfg_data == '0) begin
      cfg_inputs  = NW'(1);
      cfg_outputs = NW'(1);
    end else begin
      cfg_inputs  = (cfg_data > NW'(COLS)) ? NW'(COLS) : cfg_data;
      cfg_outputs = (cfg_data > NW'(ROWS)) ? NW'(ROWS) : cfg_data;
    end
  end

  // One weight and one element are read per cycle while issuing a row.
  always_comb begin
    issue_ctl.valid = state == S_ISSUE;
    issue_ctl.first = c == '0;
    issue_ctl.last  = c == input_last[CW-1:0];
  end

  // The store's read data arrives in the cycle after the address, so is its control.
  always_ff @(posedge clk) begin
    if (rst) begin
      read_ctl <= '0;
    end else begin
      read_ctl <= issue_ctl;
    end
  end

  fcl_store #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_store (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (in_xfer),
    .wr_item   (in_data),
    .rd_row    (k),
    .rd_col    (c),
    .weight_q  (weight_q),
    .element_q (element_q),
    .bias_q    (bias_q)
  );

  fcl_mac u_mac (
    .clk       (clk),
    .rst       (rst),
    .ctl       (read_ctl),
    .weight    (weight_q),
    .element   (element_q),
    .bias      (bias_q),
    .done      (mac_done),
    .result    (mac_result),
    .saturated (mac_sat)
  );

  // Sequencer. A row starts only once the output register is free, so a
  // finished result always has a place to land when the MAC unit reports it.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      k            <= '0;
      c            <= '0;
      out_valid    <= 1'b0;
      input_count  <= NW'(COLS);
      output_count <= NW'(ROWS);
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          fcl_pkg::REG_INPUT_COUNT:  input_count  <= cfg_inputs;
          fcl_pkg::REG_OUTPUT_COUNT: output_count <= cfg_outputs;
          default: ;
        endcase
      end

      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_xfer && in_data.mode == fcl_pkg::MODE_ELEMENT && in_data.last) begin
            k     <= '0;
            state <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (!out_valid || out_ready) begin
            c     <= '0;
            state <= S_ISSUE;
          end
        end
        S_ISSUE: begin
          if (c == input_last[CW-1:0]) begin
            state <= S_DRAIN;
          end else begin
            c <= c + 1'b1;
          end
        end
        S_DRAIN: begin
          if (mac_done) begin
            out_valid          <= 1'b1;
            res_data.out_index <= 4'(k);
            res_data.result    <= mac_result;
            res_data.saturated <= mac_sat;
            res_data.final_res <= k == output_last[RW-1:0];
            if (k == output_last[RW-1:0]) begin
              state <= S_IDLE;
            end else begin
              k     <= k + 1'b1;
              state <= S_WAIT;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // A finished result must never overwrite one that is still waiting.
  a_result_slot_free: assert property (@(posedge clk) disable iff (rst)
    mac_done |-> !out_valid)
    else $error("MAC result arrived while the output register was full");

  // The input side stays closed while any row is still in the MAC unit.
  a_no_accept_in_flight: assert property (@(posedge clk) disable iff (rst)
    (read_ctl.valid || mac_done) |-> !in_ready)
    else $error("input ready while a row is still being accumulated");

  // The column counter never runs past the configured input count.
  a_column_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_ISSUE |-> NW'(c) <= input_last)
    else $error("column counter beyond input_count");

  // A row is issued once and then drains: the issue phase ends on its last column.
  a_issue_ends_on_last: assert property (@(posedge clk) disable iff (rst)
    (state == S_ISSUE && issue_ctl.last) |=> state == S_DRAIN)
    else $error("issue phase did not end after the last column");
`endif

endmodule

### verif/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for fully_connected_layer: a queue-fed input driver, an
// output monitor and a Q8.8 layer predictor. Depends on fcl_pkg and the RTL only.
module tb;

  // Mode code that the block must ignore, and a register index it does not decode.
  localparam logic [1:0]                      MODE_UNUSED = 2'd3;
  localparam logic [fcl_pkg::CFG_INDEX_W-1:0] REG_SPARE   = 4'd9;

  localparam int NUM_SETTINGS = 8;
  localparam int DRAIN_GAP    = 48;
  localparam int HOLD_CYCLES  = 300;
  localparam int HOLD_PHASE   = 3;
  localparam int TIMEOUT_NS   = 6000000;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            in_valid = 1'b0;
  logic                            in_ready;
  fcl_pkg::in_item_t               in_data = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  fcl_pkg::out_item_t              res_data;
  logic                            cfg_we = 1'b0;
  logic [fcl_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [fcl_pkg::COUNT_W-1:0]     cfg_data = '0;

  fully_connected_layer u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res_data  (res_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Layer image kept by the predictor, updated on every accepted input transfer.
  logic signed [15:0] weight_mem [16][16];
  logic signed [15:0] bias_mem [16];
  logic signed [15:0] vector_mem [16];
  int                 cfg_inputs = 16;
  int                 cfg_outputs = 16;

  // Entries that the stimulus has already loaded. A computation must never read
  // a weight or an element that was never written, so the generator tracks them.
  bit                 wt_loaded [16][16];
  bit                 el_loaded [16];

  fcl_pkg::in_item_t  pending_items[$];
  fcl_pkg::out_item_t expected_results[$];

  int                 src_idle_pct = 13;
  int                 sink_idle_pct = 81;
  int                 hold_requests = 0;
  bit                 in_taken = 1'b0;
  int                 errors = 0;
  int                 transfers_in = 0;
  int                 results_seen = 0;
  int                 saturated_seen = 0;

  function automatic int clamp_count(input logic [fcl_pkg::COUNT_W-1:0] raw);
    if (raw < 1) return 1;
    if (raw > fcl_pkg::FIELD_LIMIT) return fcl_pkg::FIELD_LIMIT;
    return int'(raw);
  endfunction

  // Updates the layer image with each item; an element marked last also queues the bias
  // plus dot product for every output row in use, rounded half up to Q8.8 and clipped to the signed 16-bit range.
  task automatic apply_item(input fcl_pkg::in_item_t it);
    longint             acc;
    longint             q;
    fcl_pkg::out_item_t r;
    int                 k;
    int                 c;
    case (it.mode)
      fcl_pkg::MODE_WEIGHT: weight_mem[it.row][it.column] = it.value;
      fcl_pkg::MODE_BIAS:   bias_mem[it.row] = it.value;
      fcl_pkg::MODE_ELEMENT: begin
        vector_mem[it.column] = it.value;
        if (it.last) begin
          for (k = 0; k < cfg_outputs; k++) begin
            acc = longint'(bias_mem[k]) * 256;
            for (c = 0; c < cfg_inputs; c++)
              acc += longint'(weight_mem[k][c]) * longint'(vector_mem[c]);
            // An arithmetic shift is a floor division, so adding half an LSB
            // first sends ties upward.
            q = (acc + 128) >>> 8;
            r.saturated = 1'b0;
            if (q > 32767) begin
              q = 32767;
              r.saturated = 1'b1;
            end else if (q < -32768) begin
              q = -32768;
              r.saturated = 1'b1;
            end
            r.out_index = k[3:0];
            r.result    = q[15:0];
            r.final_res = (k == cfg_outputs - 1);
            expected_results.push_back(r);
          end
        end
      end
      default: ;  // the unused mode leaves the layer untouched
    endcase
  endtask

  // Input driver: a new transfer is offered only when the slot is empty or the
  // previous one was taken at the last rising edge.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (pending_items.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
        in_valid <= 1'b1;
        in_data  <= pending_items.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Output side ready. A long hold-off is counted here once requested, which
  // lets the output register fill and the block push back on its input.
  int hold_left = 0;
  int holds_granted = 0;
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (holds_granted != hold_requests) begin
      out_ready     <= 1'b0;
      hold_left     <= HOLD_CYCLES;
      holds_granted <= holds_granted + 1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end
  end

  // Monitor: results are checked against the oldest expectation, and every
  // accepted input transfer goes through the predictor.
  always @(posedge clk) begin
    in_taken = 1'b0;
    if (!rst) begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (res_data.saturated) saturated_seen++;
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result index %0d result %0d sat %0b final %0b", $time,
                   res_data.out_index, res_data.result, res_data.saturated,
                   res_data.final_res);
        end else begin
          if (res_data !== expected_results[0]) begin
            errors++;
            $display("%0t: mismatch expected index %0d result %0d sat %0b final %0b", $time,
                     expected_results[0].out_index, expected_results[0].result,
                     expected_results[0].saturated, expected_results[0].final_res);
            $display("%0t:          actual   index %0d result %0d sat %0b final %0b", $time,
                     res_data.out_index, res_data.result, res_data.saturated,
                     res_data.final_res);
          end
          void'(expected_results.pop_front());
        end
      end
      if (in_valid && in_ready) begin
        in_taken = 1'b1;
        transfers_in++;
        apply_item(in_data);
      end
    end
  end

  task automatic push_item(input logic [1:0] mode, input logic [3:0] row,
                           input logic [3:0] column, input logic [15:0] value,
                           input logic last);
    fcl_pkg::in_item_t it;
    it.mode   = mode;
    it.row    = row;
    it.column = column;
    it.value  = value;
    it.last   = last;
    pending_items.push_back(it);
    if (mode == fcl_pkg::MODE_WEIGHT) wt_loaded[row][column] = 1'b1;
    else if (mode == fcl_pkg::MODE_ELEMENT) el_loaded[column] = 1'b1;
  endtask

  // Full-range values saturate often; small ones keep most sums in range.
  function automatic logic [15:0] rand_value();
    case ($urandom_range(0, 3))
      0, 1: return 16'($urandom);
      2:    return 16'($signed($urandom_range(0, 1023)) - 512);
      default: begin
        case ($urandom_range(0, 4))
          0: return 16'h7FFF;
          1: return 16'h8000;
          2: return 16'h0000;
          3: return 16'h0100;
          default: return 16'hFFFF;
        endcase
      end
    endcase
  endfunction

  // One vector: first whatever the computation will read that is still
  // unloaded, then random rewrites and noise, then the element marked last.
  // A few sequences are cut short and never trigger.
  task automatic queue_vector();
    int r;
    int c;
    int n;
    for (r = 0; r < cfg_outputs; r++)
      for (c = 0; c < cfg_inputs; c++)
        if (!wt_loaded[r][c])
          push_item(fcl_pkg::MODE_WEIGHT, r[3:0], c[3:0], rand_value(),
                    1'($urandom_range(0, 1)));
    for (c = 0; c < cfg_inputs; c++)
      if (!el_loaded[c])
        push_item(fcl_pkg::MODE_ELEMENT, 4'($urandom), c[3:0], rand_value(), 1'b0);
    n = $urandom_range(0, 3);
    repeat (n) push_item(fcl_pkg::MODE_WEIGHT, 4'($urandom), 4'($urandom), rand_value(),
                         1'($urandom_range(0, 1)));
    n = $urandom_range(0, 2);
    repeat (n) push_item(fcl_pkg::MODE_BIAS, 4'($urandom), 4'($urandom), rand_value(),
                         1'($urandom_range(0, 1)));
    n = $urandom_range(0, 2);
    repeat (n) push_item(fcl_pkg::MODE_ELEMENT, 4'($urandom), 4'($urandom), rand_value(),
                         1'b0);
    if ($urandom_range(0, 9) == 0)
      push_item(MODE_UNUSED, 4'($urandom), 4'($urandom), 16'($urandom),
                1'($urandom_range(0, 1)));
    if ($urandom_range(0, 7) != 0)
      push_item(fcl_pkg::MODE_ELEMENT, 4'($urandom), 4'($urandom), rand_value(), 1'b1);
  endtask

  task automatic write_reg(input logic [fcl_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [fcl_pkg::COUNT_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == fcl_pkg::REG_INPUT_COUNT) cfg_inputs = clamp_count(data);
    else if (idx == fcl_pkg::REG_OUTPUT_COUNT) cfg_outputs = clamp_count(data);
  endtask

  // Every queued transfer accepted and every result delivered, then an extra
  // settling gap before the next phase.
  task automatic wait_drained();
    do @(posedge clk);
    while (pending_items.size() != 0 || in_valid || expected_results.size() != 0);
    repeat (DRAIN_GAP) @(posedge clk);
  endtask

  // Raw register values per phase; zero and 31 exercise the input-count clamp at both ends, 31 the output-count clamp.
  int in_setting  [NUM_SETTINGS] = '{3, 16, 0, 5, 31, 2, 4, 7};
  int out_setting [NUM_SETTINGS] = '{2, 1, 31, 4, 2, 3, 4, 1};

  initial begin
    int p;
    int k;
    for (k = 0; k < 16; k++) bias_mem[k] = '0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // Directed part on a one-by-one layer: both saturation directions, exact
    // extremes, ties rounding up, ignored last flags, the unused mode, and an
    // element stored earlier that is reused by a later trigger.
    write_reg(fcl_pkg::REG_INPUT_COUNT, 5'd1);
    write_reg(fcl_pkg::REG_OUTPUT_COUNT, 5'd1);
    push_item(fcl_pkg::MODE_WEIGHT,  4'd0, 4'd0, 16'h7FFF, 1'b0);
    push_item(fcl_pkg::MODE_ELEMENT, 4'd0, 4'd0, 16'h7FFF, 1'b1);
    push_item(fcl_pkg::MODE_WEIGHT,  4'd0, 4'd0, 16'h8000, 1'b1);
    push_item(fcl_pkg::MODE_ELEMENT, 4'd0, 4'd0, 16'h7FFF, 1'b1);
    push_item(fcl_pkg::MODE_ELEMENT, 4'd0, 4'd0, 16'h8000, 1'b1);
    push_item(fcl_pkg::MODE_BIAS,    4'd0, 4'd0, 16'h7FFF, 1'b1);
    push_item(fcl_pkg::MODE_WEIGHT,  4'd0, 4'd0, 16'h0000, 1'b0);
    push_item(fcl_pkg::MODE_ELEMENT, 4'd0, 4'd0, 16'h0000, 1'b1);
    push_item(fcl_pkg::MODE_BIAS,    4'd0, 4'd0, 16'h8000, 1'b0);
    push_item(fcl_pkg::MODE_ELEMENT, 4'd0, 4'd0, 16'h8000, 1'b1);
    push_item(fcl_pkg::MODE_BIAS,    4'd0, 4'd0, 16'h0000, 1'b0);
    push_item(fcl_pkg::MODE_WEIGHT,  4'd0, 4'd0, 16'h0001, 1'b0);
    push_item(fcl_pkg::MODE_ELEMENT, 4'd0, 4'd0, 16'h0080, 1'b1);
    push_item(fcl_pkg::MODE_WEIGHT,  4'd0, 4'd0, 16'hFFFF, 1'b0);
    push_item(fcl_pkg::MODE_ELEMENT, 4'd0, 4'd0, 16'h0080, 1'b1);
    push_item(fcl_pkg::MODE_ELEMENT, 4'd0, 4'd0, 16'h0081, 1'b1);
    push_item(MODE_UNUSED,           4'd15, 4'd15, 16'h7FFF, 1'b1);
    push_item(fcl_pkg::MODE_WEIGHT,  4'd15, 4'd15, 16'h1234, 1'b1);
    push_item(fcl_pkg::MODE_ELEMENT, 4'd15, 4'd15, 16'hFFFF, 1'b0);
    push_item(fcl_pkg::MODE_BIAS,    4'd15, 4'd15, 16'h0100, 1'b1);
    push_item(fcl_pkg::MODE_ELEMENT, 4'd0, 4'd15, 16'h0200, 1'b1);
    wait_drained();

    // Random part: each phase sets new counts, then queues a few vectors.
    for (p = 0; p < NUM_SETTINGS; p++) begin
      if (p < 3) begin
        src_idle_pct  = 13;
        sink_idle_pct = 81;
      end else if (p < 6) begin
        src_idle_pct  = 81;
        sink_idle_pct = 13;
      end else begin
        src_idle_pct  = 0;
        sink_idle_pct = 0;
      end
      if (p == 5) write_reg(REG_SPARE, fcl_pkg::COUNT_W'($urandom));
      write_reg(fcl_pkg::REG_INPUT_COUNT, fcl_pkg::COUNT_W'(in_setting[p]));
      write_reg(fcl_pkg::REG_OUTPUT_COUNT, fcl_pkg::COUNT_W'(out_setting[p]));
      if (p == HOLD_PHASE) hold_requests++;
      repeat ($urandom_range(2, 4)) queue_vector();
      wait_drained();
    end

    $display("Covered %0d input transfers and %0d results, %0d of them saturated,",
             transfers_in, results_seen, saturated_seen);
    $display("over %0d count settings after the directed one-by-one layer.", NUM_SETTINGS);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("fully_connected_layer test passed");
    end else begin
      $display("fully_connected_layer test failed");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("%0t: timeout with %0d results still expected", $time, expected_results.size());
    $display("fully_connected_layer test failed");
    $finish;
  end

endmodule
